FILE: sv/hte_pkg.sv
// ----------------------------------------------------------------------------
// hte_pkg
// Shared constants, types and helpers for the hex text encoder.
// ----------------------------------------------------------------------------
package hte_pkg;

    localparam int MAX_AFFIX_CHARS = 4;
    localparam int REG_CHARS       = 4;
    localparam int AFFIX_CAP       = (MAX_AFFIX_CHARS < REG_CHARS) ? MAX_AFFIX_CHARS
                                                                   : REG_CHARS;
    localparam int LEN_W           = $clog2(AFFIX_CAP + 1);
    localparam int REG_LEN_W       = 3;
    localparam int CHAR_SEL_W      = $clog2(REG_CHARS);
    localparam int MAX_CHARS       = 2 * AFFIX_CAP + 2;
    localparam int IDX_W           = $clog2(MAX_CHARS);

    typedef enum logic [1:0] {
        REG_PREFIX_CHARS,
        REG_PREFIX_LENGTH,
        REG_SEPARATOR_CHARS,
        REG_SEPARATOR_LENGTH
    } reg_index_t;

    typedef struct packed {
        logic [31:0]      prefix_chars;
        logic [LEN_W-1:0] prefix_len;
        logic [31:0]      separator_chars;
        logic [LEN_W-1:0] separator_len;
    } cfg_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } sel_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10)
        begin
            d = 8'h30 + {4'd0, nib};
        end
        else
        begin
            d = 8'h57 + {4'd0, nib};
        end
        return d;
    endfunction

    function automatic logic [LEN_W-1:0] cap_len(input logic [REG_LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        if (int'(len) > AFFIX_CAP)
        begin
            r = LEN_W'(AFFIX_CAP);
        end
        else
        begin
            r = LEN_W'(len);
        end
        return r;
    endfunction

endpackage

FILE: sv/hex_text_encoder_with_affixes.sv
// ----------------------------------------------------------------------------
// hex_text_encoder_with_affixes
// Turns raw bytes into ASCII hex text with a separator and a prefix.
// ----------------------------------------------------------------------------
// Each accepted byte gives one character per cycle on the output stream while
// m_tready is held high: the separator (left out when tuser marks the first byte
// of a buffer), the prefix, then two lower-case hex digits, high nibble first,
// the last one with tlast. A run is 2 + separator length + prefix length
// characters, 2 to 10; the next byte is taken in the cycle the run's last
// character moves to the output register. Prefix and separator are to be set
// over the register port while the stream is idle; the block does not enforce it.
module hex_text_encoder_with_affixes
    import hte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // first_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_char
    output logic        m_tlast,   // last_of_run
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0]          prefix_chars_reg;
    logic [REG_LEN_W-1:0] prefix_length_reg;
    logic [31:0]          separator_chars_reg;
    logic [REG_LEN_W-1:0] separator_length_reg;

    logic                 item_valid_reg;
    logic [7:0]           item_byte_reg;
    logic                 item_first_reg;
    logic [IDX_W-1:0]     idx_reg;

    logic                 out_valid_reg;
    logic [7:0]           out_char_reg;
    logic                 out_last_reg;

    cfg_t                 cfg;
    sel_t                 sel;
    reg_index_t           wr_index;
    logic                 cfg_write;
    logic                 out_load;
    logic                 item_done;
    logic                 in_accept;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign wr_index  = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_chars_reg     <= '0;
            prefix_length_reg    <= '0;
            separator_chars_reg  <= '0;
            separator_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (wr_index)
                REG_PREFIX_CHARS:     prefix_chars_reg     <= pwdata;
                REG_PREFIX_LENGTH:    prefix_length_reg    <= pwdata[REG_LEN_W-1:0];
                REG_SEPARATOR_CHARS:  separator_chars_reg  <= pwdata;
                REG_SEPARATOR_LENGTH: separator_length_reg <= pwdata[REG_LEN_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (wr_index)
            REG_PREFIX_CHARS:     prdata = prefix_chars_reg;
            REG_PREFIX_LENGTH:    prdata = {{(32-REG_LEN_W){1'b0}}, prefix_length_reg};
            REG_SEPARATOR_CHARS:  prdata = separator_chars_reg;
            REG_SEPARATOR_LENGTH: prdata = {{(32-REG_LEN_W){1'b0}}, separator_length_reg};
            default:              prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.prefix_chars    = prefix_chars_reg;
        cfg.prefix_len      = cap_len(prefix_length_reg);
        cfg.separator_chars = separator_chars_reg;
        cfg.separator_len   = cap_len(separator_length_reg);
    end

    hte_char_sel u_char_sel (
        .cfg        (cfg),
        .item_byte  (item_byte_reg),
        .item_first (item_first_reg),
        .idx        (idx_reg),
        .sel        (sel)
    );

    assign out_load  = item_valid_reg && (!out_valid_reg || m_tready);
    assign item_done = out_load && sel.last;
    assign s_tready  = !item_valid_reg || item_done;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else if (in_accept)
        begin
            item_valid_reg <= 1'b1;
            idx_reg        <= '0;
        end
        else if (item_done)
        begin
            item_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else if (out_load)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_byte_reg  <= s_tdata;
            item_first_reg <= s_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_char_reg <= sel.ch;
            out_last_reg <= sel.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    a_accept_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready && item_valid_reg) |-> item_done)
        else $error("new byte taken while current run unfinished");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> (int'(idx_reg) < MAX_CHARS))
        else $error("character index past longest run");

    a_restart_idx: assert property (@(posedge clk) disable iff (!rst_n)
        item_done |=> (idx_reg == '0))
        else $error("index not cleared after run end");

    a_last_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !sel.last) |=> item_valid_reg)
        else $error("run dropped before its last character");

endmodule

FILE: sv/hte_char_sel.sv
// ----------------------------------------------------------------------------
// hte_char_sel
// Picks the character at a given position of one byte's text run.
// ----------------------------------------------------------------------------
module hte_char_sel
    import hte_pkg::*;
(
    input  cfg_t             cfg,
    input  logic [7:0]       item_byte,
    input  logic             item_first,
    input  logic [IDX_W-1:0] idx,
    output sel_t             sel
);

    logic [IDX_W-1:0]      sep_end;
    logic [IDX_W-1:0]      pre_end;
    logic [IDX_W-1:0]      sep_off;
    logic [IDX_W-1:0]      pre_off;
    logic [CHAR_SEL_W-1:0] sep_k;
    logic [CHAR_SEL_W-1:0] pre_k;

    always_comb
    begin
        sep_end = item_first ? '0 : IDX_W'(cfg.separator_len);
        pre_end = sep_end + IDX_W'(cfg.prefix_len);
        sep_off = idx;
        pre_off = idx - sep_end;
        sep_k   = sep_off[CHAR_SEL_W-1:0];
        pre_k   = pre_off[CHAR_SEL_W-1:0];
        sel     = '0;
        if (idx < sep_end)
        begin
            sel.ch = cfg.separator_chars[8*sep_k +: 8];
        end
        else if (idx < pre_end)
        begin
            sel.ch = cfg.prefix_chars[8*pre_k +: 8];
        end
        else if (idx == pre_end)
        begin
            sel.ch = hex_digit(item_byte[7:4]);
        end
        else
        begin
            sel.ch   = hex_digit(item_byte[3:0]);
            sel.last = 1'b1;
        end
    end

endmodule
